// ----- rtl/pfsq_pkg.sv -----
// Shared types, codes and symbol helpers for the 6x6 pair cipher square.
`timescale 1ns / 1ps
`default_nettype none
package pfsq_pkg;

  localparam int CELLS = 36;
  localparam logic [5:0] LAST_CELL = 6'd35;
  localparam logic [5:0] FULL_COUNT = 6'd36;
  localparam logic [5:0] LETTERS = 6'd26;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_KEY = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_PAIR = 2'd3;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_NO_SYMBOL = 2'd1;
  localparam logic [1:0] STAT_NOT_READY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       we;
    logic [5:0] sym;
    logic [5:0] slot;
    logic [7:0] ascii;
  } store_wr_t;

  typedef struct packed {
    logic       sc_re;
    logic [5:0] sc_a;
    logic [5:0] sc_b;
    logic       cs_re;
    logic [5:0] cs_a;
    logic [5:0] cs_b;
  } store_rd_t;

  typedef struct packed {
    logic [5:0] sc_da;
    logic [5:0] sc_db;
    logic [7:0] cs_da;
    logic [7:0] cs_db;
  } store_rdata_t;

  function automatic logic sym_ok(input logic [7:0] c);
    return ((c >= CH_A) && (c <= CH_Z)) || ((c >= CH_0) && (c <= CH_9));
  endfunction

  function automatic logic [5:0] sym_idx(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    if ((c >= CH_A) && (c <= CH_Z)) begin
      r = 6'(c - CH_A);
    end else if ((c >= CH_0) && (c <= CH_9)) begin
      r = 6'(c - CH_0) + LETTERS;
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_ascii(input logic [5:0] s);
    logic [7:0] r;
    if (s < LETTERS) begin
      r = CH_A + 8'(s);
    end else begin
      r = CH_0 + 8'(s - LETTERS);
    end
    return r;
  endfunction

  // row = p / 6 for p < 36, via multiply by 43 and shift by 8
  function automatic logic [2:0] cell_row(input logic [5:0] p);
    logic [11:0] prod;
    prod = 12'(p) * 12'd43;
    return prod[10:8];
  endfunction

  function automatic logic [2:0] cell_col(input logic [5:0] p, input logic [2:0] row);
    logic [5:0] base;
    base = 6'(row) * 6'd6;
    return 3'(p - base);
  endfunction

  function automatic logic [5:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return 6'(row) * 6'd6 + 6'(col);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfsq_store.sv -----
// Key square storage: cell-to-symbol and symbol-to-cell memories, placed flags.
`timescale 1ns / 1ps
`default_nettype none
module pfsq_store (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  clear,
  input  wire pfsq_pkg::store_wr_t   wr,
  input  wire pfsq_pkg::store_rd_t   rd,
  output pfsq_pkg::store_rdata_t     rdata,
  output logic [pfsq_pkg::CELLS-1:0] placed
);

  logic [7:0] cs_mem [pfsq_pkg::CELLS];
  logic [5:0] sc_mem [pfsq_pkg::CELLS];
  logic [pfsq_pkg::CELLS-1:0] placed_r;
  logic [5:0] sc_da_r, sc_db_r;
  logic [7:0] cs_da_r, cs_db_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      cs_mem[wr.slot] <= wr.ascii;
      sc_mem[wr.sym]  <= wr.slot;
    end
    if (rd.sc_re) begin
      sc_da_r <= sc_mem[rd.sc_a];
      sc_db_r <= sc_mem[rd.sc_b];
    end
    if (rd.cs_re) begin
      cs_da_r <= cs_mem[rd.cs_a];
      cs_db_r <= cs_mem[rd.cs_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placed_r <= '0;
    end else if (clear) begin
      placed_r <= '0;
    end else if (wr.we) begin
      placed_r[wr.sym] <= 1'b1;
    end
  end

  assign placed = placed_r;
  assign rdata = '{sc_da: sc_da_r, sc_db: sc_db_r, cs_da: cs_da_r, cs_db: cs_db_r};

endmodule
`default_nettype wire

// ----- rtl/pfsq_ctrl.sv -----
// Sequencer: shared placement unit, finish walk and pair lookup steps.
`timescale 1ns / 1ps
`default_nettype none
module pfsq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [1:0]             in_func,
  input  wire logic [7:0]             in_char_a,
  input  wire logic [7:0]             in_char_b,
  input  wire logic                   out_busy,
  input  wire logic [pfsq_pkg::CELLS-1:0] placed,
  input  wire pfsq_pkg::store_rdata_t rdata,
  output logic                        in_ready,
  output logic                        clear,
  output pfsq_pkg::store_wr_t         wr,
  output pfsq_pkg::store_rd_t         rd,
  output logic                        resp_load,
  output logic [1:0]                  resp_stat
);

  pfsq_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic       ready_r, ready_nxt;
  logic [1:0] stat_r, stat_nxt;

  logic       accept;
  logic       ok_a, ok_b;
  logic [5:0] idx_a, idx_b;
  logic [5:0] psym;
  logic       preq, pdo;
  logic [2:0] row_a, row_b, col_a, col_b;

  assign accept = in_valid && in_ready;
  assign idx_a  = pfsq_pkg::sym_idx(in_char_a);
  assign idx_b  = pfsq_pkg::sym_idx(in_char_b);
  assign ok_a   = pfsq_pkg::sym_ok(in_char_a);
  assign ok_b   = pfsq_pkg::sym_ok(in_char_b);

  assign row_a = pfsq_pkg::cell_row(rdata.sc_da);
  assign row_b = pfsq_pkg::cell_row(rdata.sc_db);
  assign col_a = pfsq_pkg::cell_col(rdata.sc_da, row_a);
  assign col_b = pfsq_pkg::cell_col(rdata.sc_db, row_b);

  // shared placement unit: key character or finish walk
  assign psym = (state_r == pfsq_pkg::ST_FILL) ? cnt_r : idx_a;
  assign preq = (state_r == pfsq_pkg::ST_FILL) ||
                (accept && (in_func == pfsq_pkg::FUNC_KEY) && ok_a);
  assign pdo  = preq && !placed[psym] && (fill_r != pfsq_pkg::FULL_COUNT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfsq_pkg::ST_IDLE: begin
        if (accept && (in_func == pfsq_pkg::FUNC_FINISH)) begin
          state_nxt = pfsq_pkg::ST_FILL;
        end else if (accept && (in_func == pfsq_pkg::FUNC_PAIR)) begin
          state_nxt = (stat_nxt == pfsq_pkg::STAT_OK) ? pfsq_pkg::ST_LOOK
                                                      : pfsq_pkg::ST_RESP;
        end
      end
      pfsq_pkg::ST_FILL: begin
        if (cnt_r == pfsq_pkg::LAST_CELL) begin
          state_nxt = pfsq_pkg::ST_IDLE;
        end
      end
      pfsq_pkg::ST_LOOK: state_nxt = pfsq_pkg::ST_RESP;
      pfsq_pkg::ST_RESP: begin
        if (!out_busy) begin
          state_nxt = pfsq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == pfsq_pkg::ST_IDLE);
    clear     = accept && (in_func == pfsq_pkg::FUNC_CLEAR);
    resp_load = (state_r == pfsq_pkg::ST_RESP) && !out_busy;
    resp_stat = stat_r;
    wr.we     = pdo;
    wr.sym    = psym;
    wr.slot   = fill_r;
    wr.ascii  = pfsq_pkg::sym_ascii(psym);
    rd.sc_re  = accept && (in_func == pfsq_pkg::FUNC_PAIR);
    rd.sc_a   = idx_a;
    rd.sc_b   = idx_b;
    rd.cs_re  = (state_r == pfsq_pkg::ST_LOOK);
    rd.cs_a   = pfsq_pkg::cell_addr(row_a, col_b);
    rd.cs_b   = pfsq_pkg::cell_addr(row_b, col_a);
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    ready_nxt = ready_r;
    stat_nxt  = stat_r;
    if (state_r == pfsq_pkg::ST_FILL) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == pfsq_pkg::LAST_CELL) begin
        ready_nxt = 1'b1;
      end
    end
    if (accept && (in_func == pfsq_pkg::FUNC_FINISH)) begin
      cnt_nxt = 6'd0;
    end
    if (accept && (in_func == pfsq_pkg::FUNC_CLEAR)) begin
      fill_nxt  = 6'd0;
      ready_nxt = 1'b0;
    end else if (pdo) begin
      fill_nxt = fill_r + 6'd1;
    end
    if (accept && (in_func == pfsq_pkg::FUNC_PAIR)) begin
      if (!ready_r) begin
        stat_nxt = pfsq_pkg::STAT_NOT_READY;
      end else if (!ok_a || !ok_b || !placed[idx_a] || !placed[idx_b]) begin
        stat_nxt = pfsq_pkg::STAT_NO_SYMBOL;
      end else begin
        stat_nxt = pfsq_pkg::STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfsq_pkg::ST_IDLE;
      cnt_r   <= 6'd0;
      fill_r  <= 6'd0;
      ready_r <= 1'b0;
      stat_r  <= pfsq_pkg::STAT_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/playfair_square_pair_cipher_unit.sv -----
// Top level of the 6x6 key square pair cipher unit.
// Clear and key commands leave the unit idle; in_ready stays high after them.
// Finish walks all 36 symbols through the placement unit, one per cycle.
// Pair: out_valid rises after the two registered memory reads and the output register
// (error results skip the reads); next item taken after the result registers.
// Reset clears placed flags, fill count and finished flag; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module playfair_square_pair_cipher_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_char_a,
  input  wire logic [7:0] in_char_b,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_a,
  output logic [7:0]      out_b,
  output logic [1:0]      out_status
);

  pfsq_pkg::store_wr_t    wr;
  pfsq_pkg::store_rd_t    rd;
  pfsq_pkg::store_rdata_t rdata;
  logic [pfsq_pkg::CELLS-1:0] placed;
  logic       clear;
  logic       resp_load;
  logic [1:0] resp_stat;
  logic       out_valid_r;
  logic [7:0] out_a_r, out_b_r;
  logic [1:0] out_status_r;
  logic       out_busy;

  assign out_busy = out_valid_r && !out_ready;

  pfsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_char_a (in_char_a),
    .in_char_b (in_char_b),
    .out_busy  (out_busy),
    .placed    (placed),
    .rdata     (rdata),
    .in_ready  (in_ready),
    .clear     (clear),
    .wr        (wr),
    .rd        (rd),
    .resp_load (resp_load),
    .resp_stat (resp_stat)
  );

  pfsq_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .wr     (wr),
    .rd     (rd),
    .rdata  (rdata),
    .placed (placed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status_r <= resp_stat;
      if (resp_stat == pfsq_pkg::STAT_OK) begin
        out_a_r <= rdata.cs_da;
        out_b_r <= rdata.cs_db;
      end else begin
        out_a_r <= 8'd0;
        out_b_r <= 8'd0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// ----- rtl/pfsq_checker.sv -----
// Port-level checks for the pair cipher unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pfsq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_a,
  input wire logic [7:0] out_b,
  input wire logic [1:0] out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b) &&
    $stable(out_status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pfsq_pkg::STAT_OK) |-> (out_a == 8'd0) && (out_b == 8'd0))
    else $error("error result carries nonzero characters");

  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == pfsq_pkg::FUNC_FINISH) |=> !in_ready)
    else $error("ready during finish walk");

  a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == pfsq_pkg::FUNC_PAIR) |=> !in_ready)
    else $error("ready right after pair transfer");

endmodule

bind playfair_square_pair_cipher_unit pfsq_checker u_pfsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_func    (in_func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_a      (out_a),
  .out_b      (out_b),
  .out_status (out_status)
);
`default_nettype wire

// ----- dv/pfsq_pair_checker.sv -----
// Checker for the 6x6 pair cipher unit: predicts each pair result and compares.
`timescale 1ns / 1ps
module pfsq_pair_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_char_a,
  input  wire logic [7:0] in_char_b,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_a,
  input  wire logic [7:0] out_b,
  input  wire logic [1:0] out_status,
  output int              fail_count,
  output int              outstanding
);
  import pfsq_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [1:0] status;
  } pair_result_t;

  pair_result_t result_q[$];

  logic [7:0] sq_char[CELLS];
  logic [5:0] sq_pos[CELLS];
  bit         sq_used[CELLS];
  int         sq_fill;
  bit         sq_done;

  function automatic int symbol_index(input logic [7:0] c);
    if (c >= CH_A && c <= CH_Z) return int'(c - CH_A);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0) + int'(LETTERS);
    return -1;
  endfunction

  function automatic logic [7:0] symbol_char(input int s);
    if (s < int'(LETTERS)) return CH_A + 8'(s);
    return CH_0 + 8'(s - int'(LETTERS));
  endfunction

  task automatic place_symbol(input int s);
    if (s < 0 || sq_used[s] || sq_fill >= CELLS) return;
    sq_char[sq_fill] = symbol_char(s);
    sq_pos[s] = 6'(sq_fill);
    sq_used[s] = 1'b1;
    sq_fill++;
  endtask

  task automatic clear_square();
    foreach (sq_used[i]) sq_used[i] = 1'b0;
    sq_fill = 0;
    sq_done = 1'b0;
  endtask

  function automatic pair_result_t encipher_pair(input logic [7:0] a, input logic [7:0] b);
    pair_result_t r;
    int sa, sb, ra, ca, rb, cb;
    r = '{8'd0, 8'd0, STAT_OK};
    if (!sq_done) begin
      r.status = STAT_NOT_READY;
      return r;
    end
    sa = symbol_index(a);
    sb = symbol_index(b);
    if (sa < 0 || sb < 0 || !sq_used[sa] || !sq_used[sb]) begin
      r.status = STAT_NO_SYMBOL;
      return r;
    end
    ra = int'(sq_pos[sa]) / 6;
    ca = int'(sq_pos[sa]) % 6;
    rb = int'(sq_pos[sb]) / 6;
    cb = int'(sq_pos[sb]) % 6;
    r.a = sq_char[ra * 6 + cb];
    r.b = sq_char[rb * 6 + ca];
    return r;
  endfunction

  task automatic apply_command(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b);
    case (f)
      FUNC_CLEAR: clear_square();
      FUNC_KEY: place_symbol(symbol_index(a));
      FUNC_FINISH: begin
        for (int s = 0; s < CELLS; s++) place_symbol(s);
        sq_done = 1'b1;
      end
      default: result_q.push_back(encipher_pair(a, b));
    endcase
  endtask

  task automatic note_failure(input string what, input pair_result_t want);
    if (fail_count < 10) begin
      $display("%0t %s: got a=%h b=%h status=%0d, expected a=%h b=%h status=%0d",
               $realtime, what, out_a, out_b, out_status, want.a, want.b, want.status);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    pair_result_t want;
    if (!rst_n) begin
      clear_square();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          note_failure("unexpected result transfer", '{8'd0, 8'd0, STAT_OK});
        end else begin
          want = result_q.pop_front();
          if (out_a !== want.a || out_b !== want.b || out_status !== want.status) begin
            note_failure("pair result mismatch", want);
          end
        end
      end
      if (in_valid && in_ready) apply_command(in_func, in_char_a, in_char_b);
    end
    outstanding = result_q.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the 6x6 pair cipher unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
  import pfsq_pkg::*;

  localparam int RUN_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_func = FUNC_CLEAR;
  logic [7:0] in_char_a = 8'd0;
  logic [7:0] in_char_b = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [1:0] out_status;

  int fail_count;
  int outstanding;
  int send_idle_pct = 22;
  int recv_idle_pct = 57;
  int sent_count = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  playfair_square_pair_cipher_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_char_a(in_char_a), .in_char_b(in_char_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_status(out_status)
  );

  pfsq_pair_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_char_a(in_char_a), .in_char_b(in_char_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_status(out_status),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[playfair_square_pair_cipher_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] symbol_char(input int s);
    if (s < int'(LETTERS)) return CH_A + 8'(s);
    return CH_0 + 8'(s - int'(LETTERS));
  endfunction

  function automatic logic [7:0] rand_symbol();
    return symbol_char($urandom_range(0, CELLS - 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_item(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_char_a <= a;
    in_char_b <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!(f == FUNC_KEY && !sym_ok(a))) sent_count++;
  endtask

  task automatic send_pair();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0: send_item(FUNC_PAIR, rand_byte(), rand_symbol());
      1: send_item(FUNC_PAIR, rand_symbol(), rand_byte());
      2: begin
        c = rand_symbol();
        send_item(FUNC_PAIR, c, c);
      end
      default: send_item(FUNC_PAIR, rand_symbol(), rand_symbol());
    endcase
  endtask

  task automatic run_session();
    int order[CELLS];
    int j, tmp, key_len, n_pairs;
    if ($urandom_range(0, 9) != 0) send_item(FUNC_CLEAR, rand_byte(), rand_byte());
    if ($urandom_range(0, 4) == 0) begin
      // every symbol keyed in shuffled order, then a few that no longer fit
      foreach (order[i]) order[i] = i;
      for (int i = CELLS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      foreach (order[i]) send_item(FUNC_KEY, symbol_char(order[i]), rand_byte());
      repeat ($urandom_range(1, 3)) send_item(FUNC_KEY, rand_symbol(), rand_byte());
    end else begin
      key_len = $urandom_range(0, 20);
      repeat (key_len) begin
        if ($urandom_range(0, 7) == 0) send_item(FUNC_KEY, rand_byte(), rand_byte());
        else send_item(FUNC_KEY, rand_symbol(), rand_byte());
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_item(FUNC_FINISH, rand_byte(), rand_byte());
      if ($urandom_range(0, 9) == 0) send_item(FUNC_FINISH, rand_byte(), rand_byte());
    end
    n_pairs = $urandom_range(1, 25);
    repeat (n_pairs) begin
      if ($urandom_range(0, 19) == 0) send_item(2'($urandom_range(0, 3)), rand_byte(), rand_byte());
      else send_pair();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(FUNC_PAIR, "A", "B");
    send_item(FUNC_KEY, "Z", 8'h00);
    send_item(FUNC_KEY, "0", 8'hFF);
    send_item(FUNC_KEY, "9", 8'h00);
    send_item(FUNC_KEY, "A", 8'h00);
    send_item(FUNC_KEY, "Z", 8'h00);
    send_item(FUNC_KEY, "a", 8'h00);
    send_item(FUNC_KEY, 8'hFF, 8'h00);
    send_item(FUNC_KEY, 8'h00, 8'h00);
    send_item(FUNC_KEY, "@", 8'h00);
    send_item(FUNC_KEY, "[", 8'h00);
    send_item(FUNC_KEY, "/", 8'h00);
    send_item(FUNC_KEY, ":", 8'h00);
    send_item(FUNC_FINISH, 8'hFF, 8'hFF);
    send_item(FUNC_PAIR, "A", "Z");
    send_item(FUNC_PAIR, "0", "9");
    send_item(FUNC_PAIR, "K", "K");
    send_item(FUNC_PAIR, "@", "A");
    send_item(FUNC_PAIR, "A", 8'hFF);
    send_item(FUNC_FINISH, 8'h00, 8'h00);
    send_item(FUNC_KEY, "Q", 8'h00);
    send_item(FUNC_PAIR, "Q", "Z");
    send_item(FUNC_CLEAR, 8'h00, 8'h00);
    send_item(FUNC_PAIR, "Q", "Z");

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (sent_count < (phase + 1) * RUN_ITEMS / 3) run_session();
    end
    in_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[playfair_square_pair_cipher_unit] OK");
    end else begin
      $display("[playfair_square_pair_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pfsq_pkg.sv
rtl/pfsq_store.sv
rtl/pfsq_ctrl.sv
rtl/playfair_square_pair_cipher_unit.sv
rtl/pfsq_checker.sv
dv/pfsq_pair_checker.sv
dv/tb.sv
